// File: hw/rtl/hlafp_pkg.sv
// Package: shared types, constants and codes for the hole list allocator.
`timescale 1ns / 1ps

package hlafp_pkg;

   localparam int MAX_HOLES_DEF = 16;
   localparam int ADDR_BITS_DEF = 16;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] POL_FIRST = 2'd0;
   localparam logic [1:0] POL_BEST  = 2'd1;
   localparam logic [1:0] POL_WORST = 2'd2;

   localparam logic CSR_FIT_POLICY = 1'b0;
   localparam logic CSR_TOTAL_SIZE = 1'b1;

   localparam logic [15:0] TOTAL_SIZE_RESET = 16'd1024;

   typedef struct packed {
      logic        func;
      logic [15:0] request_size;
      logic [15:0] free_base;
      logic [7:0]  request_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] granted_base;
      logic [4:0]  free_holes;
      logic [7:0]  result_tag;
   } rsp_type;

   // Commands broadcast to every cell
   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_LOAD  = 3'd1,  // cell 0 takes a new single hole, others keep
      CMD_SHRNK = 3'd2,  // target cell advances base / shrinks length
      CMD_DEL   = 3'd3,  // cells at and above target take upper neighbor
      CMD_INS   = 3'd4,  // cells above target take lower neighbor, target new
      CMD_SETL  = 3'd5,  // target cell sets length
      CMD_SETBL = 3'd6   // target cell sets base and length
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] base;
      logic [31:0] len;
   } ctl_type;

endpackage

// File: hw/rtl/hole_list_allocator_fit_policy.sv
// Top level: hole table allocator with first, best and worst fit policies.
//
// Usage: pulse start with a request word on req_word while busy is low. The
// request is func (0 allocate, 1 free), request_size, free_base and a tag.
// Exactly one response word appears on rsp_word with rsp_valid high for one
// cycle; the receiver cannot stall it, so it must take it that cycle.
// Scan: an allocate or free scans the hole table one slot a cycle; best and
// worst fit and free scan every hole, first fit stops at the first hole that
// fits. The request then passes the update and response states. Busy is high
// from acceptance on and falls in the response cycle, so the next request can
// be taken at the edge ending it.
// Table updates (shrink, delete, insert, set) go to the row of cells in the
// update state; on insert and delete each cell shifts with its neighbor. A
// free merging on both sides drops the upper hole in the response state.
// CSR: csr_we with csr_index 0 sets fit_policy, 1 sets total_size and
// rebuilds the table as one hole from zero. Write only while idle.
// Reset: synchronous, active high; policy first fit, total size 1024,
// one hole of 1024 at address zero. No clearing pass is needed.
`timescale 1ns / 1ps

module hole_list_allocator_fit_policy #(
   parameter int MAX_HOLES = hlafp_pkg::MAX_HOLES_DEF,
   parameter int ADDR_BITS = hlafp_pkg::ADDR_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  hlafp_pkg::req_type req_word,
   output logic               rsp_valid,
   output hlafp_pkg::rsp_type rsp_word,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);
   import hlafp_pkg::*;

   localparam int IB = $clog2(MAX_HOLES);
   localparam int CB = $clog2(MAX_HOLES + 1);
   localparam logic [ADDR_BITS:0] AMASK = {1'b0, {ADDR_BITS{1'b1}}};

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_UPD  = 4'b0100,
      S_RSP  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           pol_ff;
   logic [CB-1:0]        cnt_ff, cnt_in;
   logic [CB-1:0]        k_ff, k_in;
   logic [CB-1:0]        pick_ff, pick_in;
   logic                 found_ff, found_in;
   logic [CB-1:0]        pos_ff, pos_in;
   logic                 pos_done_ff, pos_done_in;
   req_type              req_ff;
   rsp_type              rsp_ff, rsp_in;
   logic                 rv_ff;
   logic                 dbl_ff;
   logic [ADDR_BITS-1:0] size_a, base_a;

   logic [ADDR_BITS-1:0] cb [MAX_HOLES];
   logic [ADDR_BITS-1:0] cl [MAX_HOLES];
   ctl_type              ctl;
   logic [IB-1:0]        tgt;
   ctl_type              ctl_cells;
   logic [IB-1:0]        tgt_cells;

   // Row of cells
   for (genvar g = 0; g < MAX_HOLES; g++) begin : g_cell
      logic [ADDR_BITS-1:0] lb, ll, hb, hl;
      if (g == 0) begin : g_lo
         assign lb = '0;
         assign ll = '0;
      end else begin : g_lon
         assign lb = cb[g-1];
         assign ll = cl[g-1];
      end
      if (g == MAX_HOLES - 1) begin : g_hi
         assign hb = '0;
         assign hl = '0;
      end else begin : g_hin
         assign hb = cb[g+1];
         assign hl = cl[g+1];
      end
      hlafp_cell #(.ADDR_BITS(ADDR_BITS), .IDX_BITS(IB), .MY_IDX(g)) u_cell (
         .clock(clock), .ctl(ctl_cells), .target(tgt_cells),
         .lo_base(lb), .lo_len(ll), .hi_base(hb), .hi_len(hl),
         .base(cb[g]), .len(cl[g]));
   end

   assign size_a = ADDR_BITS'(req_ff.request_size);
   assign base_a = ADDR_BITS'(req_ff.free_base);

   // Scan cursor reads
   logic [IB-1:0]        k_i, pk_i, pm_i, ps_i;
   logic [ADDR_BITS-1:0] lk, bk, lpk, bpk, lpm, bpm, lps, bps;
   assign k_i  = k_ff[IB-1:0];
   assign pk_i = pick_ff[IB-1:0];
   assign ps_i = pos_ff[IB-1:0];
   assign pm_i = ps_i - 1'b1;
   assign lk = cl[k_i];   assign bk = cb[k_i];
   assign lpk = cl[pk_i]; assign bpk = cb[pk_i];
   assign lpm = cl[pm_i]; assign bpm = cb[pm_i];
   assign lps = cl[ps_i]; assign bps = cb[ps_i];

   // Free merge decisions
   logic              mp, mn;
   logic [ADDR_BITS:0] psum, plen, nsum, nlen, newbase_w, newlen_w;
   assign psum = {1'b0, bpm} + {1'b0, lpm};
   assign plen = {1'b0, lpm} + {1'b0, size_a};
   assign mp = (pos_ff != '0) && (psum == {1'b0, base_a}) && (plen <= AMASK);
   assign newbase_w = mp ? {1'b0, bpm} : {1'b0, base_a};
   assign newlen_w  = mp ? plen : {1'b0, size_a};
   assign nsum = newbase_w + newlen_w;
   assign nlen = newlen_w + {1'b0, lps};
   assign mn = (pos_ff < cnt_ff) && (nsum == {1'b0, bps}) && (nlen <= AMASK);

   logic scan_end, fits, better;
   assign scan_end = (k_ff >= cnt_ff);
   assign fits = (lk >= size_a);
   always_comb begin
      unique case (pol_ff)
         POL_BEST:  better = !found_ff || (lk < lpk);
         POL_WORST: better = !found_ff || (lk > lpk);
         default:   better = !found_ff;
      endcase
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_word  = rsp_ff;
   assign tgt       = (req_ff.func == FUNC_ALLOC) ? pk_i :
                      ((mp) ? pm_i : ps_i);

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      pick_in     = pick_ff;
      found_in    = found_ff;
      pos_in      = pos_ff;
      pos_done_in = pos_done_ff;
      rsp_in      = rsp_ff;
      ctl.cmd     = CMD_NONE;
      ctl.base    = 32'(newbase_w);
      ctl.len     = 32'(size_a);
      unique case (state_ff)
         S_IDLE: begin
            if (csr_we && csr_index == CSR_TOTAL_SIZE) begin
               ctl.cmd = CMD_LOAD;
               ctl.len = 32'(ADDR_BITS'(csr_wdata));
               cnt_in  = (ADDR_BITS'(csr_wdata) != '0) ? CB'(1) : '0;
            end else if (start) begin
               state_in    = S_SCAN;
               k_in        = '0;
               found_in    = 1'b0;
               pick_in     = '0;
               pos_in      = '0;
               pos_done_in = 1'b0;
            end
         end
         S_SCAN: begin
            if (scan_end) begin
               state_in = S_UPD;
            end else begin
               k_in = k_ff + 1'b1;
               if (req_ff.func == FUNC_ALLOC) begin
                  if (fits && better) begin
                     pick_in  = k_ff;
                     found_in = 1'b1;
                  end
                  if (fits && (pol_ff != POL_BEST) && (pol_ff != POL_WORST))
                     state_in = S_UPD;
               end else if (!pos_done_ff) begin
                  if (bk < base_a) pos_in = k_ff + 1'b1;
                  else pos_done_in = 1'b1;
               end
            end
         end
         S_UPD: begin
            state_in = S_RSP;
            rsp_in.result_tag   = req_ff.request_tag;
            rsp_in.granted_base = '0;
            rsp_in.status       = ST_DONE;
            if (req_ff.func == FUNC_ALLOC) begin
               if (size_a == '0 || !found_in) begin
                  rsp_in.status = ST_NOFIT;
               end else begin
                  rsp_in.granted_base = 16'(bpk);
                  if (lpk == size_a) begin
                     ctl.cmd = CMD_DEL;
                     cnt_in  = cnt_ff - 1'b1;
                  end else begin
                     ctl.cmd = CMD_SHRNK;
                  end
               end
            end else if (size_a != '0) begin
               if (mp && mn) begin
                  ctl.cmd = CMD_SETL;
                  ctl.len = 32'(newlen_w + {1'b0, lps});
               end else if (mp) begin
                  ctl.cmd = CMD_SETL;
                  ctl.len = 32'(newlen_w);
               end else if (mn) begin
                  ctl.cmd  = CMD_SETBL;
                  ctl.base = 32'(base_a);
                  ctl.len  = 32'(nlen);
               end else if (cnt_ff >= CB'(MAX_HOLES)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  ctl.cmd  = CMD_INS;
                  ctl.base = 32'(base_a);
                  cnt_in   = cnt_ff + 1'b1;
               end
            end
         end
         S_RSP: begin
            state_in = S_IDLE;
            // Report the count after the upper hole of a double merge is dropped
            rsp_in.free_holes = 5'(dbl_ff ? cnt_ff - 1'b1 : cnt_ff);
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Double merge removes the upper hole in the response state
   ctl_type ctl_eff;
   logic [IB-1:0] tgt_eff;
   always_comb begin
      ctl_eff = ctl;
      if (state_ff == S_RSP && dbl_ff) begin
         ctl_eff.cmd = CMD_DEL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pol_ff   <= POL_FIRST;
         cnt_ff   <= CB'(1);
         rv_ff    <= 1'b0;
         dbl_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= (state_ff == S_RSP && dbl_ff) ? cnt_ff - 1'b1 : cnt_in;
         rv_ff    <= (state_ff == S_RSP);
         dbl_ff   <= (state_ff == S_UPD) && req_ff.func == FUNC_FREE &&
                     size_a != '0 && mp && mn;
         if (csr_we && csr_index == CSR_FIT_POLICY && state_ff == S_IDLE)
            pol_ff <= csr_wdata[1:0];
      end
      k_ff        <= k_in;
      pick_ff     <= pick_in;
      found_ff    <= found_in;
      pos_ff      <= pos_in;
      pos_done_ff <= pos_done_in;
      rsp_ff      <= rsp_in;
      if (start && state_ff == S_IDLE) req_ff <= req_word;
   end

   assign tgt_eff = ps_i;

   // Cells see delete of upper slot on double merge; load the reset hole in reset
   always_comb begin
      ctl_cells = ctl_eff;
      if (reset) begin
         ctl_cells.cmd = CMD_LOAD;
         ctl_cells.len = 32'(TOTAL_SIZE_RESET);
      end
   end
   assign tgt_cells = (state_ff == S_RSP && dbl_ff) ? tgt_eff : tgt;

   // Assertions
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CB'(MAX_HOLES)) else $error("hole count out of range");
   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      rv_ff |=> !rv_ff) else $error("response longer than one cycle");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RSP) |=> (rv_ff && !busy)) else $error("response lost");

endmodule

// File: hw/rtl/hlafp_cell.sv
// One hole slot of the table; shifts with its neighbors on insert and delete.
`timescale 1ns / 1ps

module hlafp_cell #(
   parameter int ADDR_BITS = hlafp_pkg::ADDR_BITS_DEF,
   parameter int IDX_BITS  = 4,
   parameter int MY_IDX    = 0
) (
   input  logic                  clock,
   input  hlafp_pkg::ctl_type    ctl,
   input  logic [IDX_BITS-1:0]   target,
   input  logic [ADDR_BITS-1:0]  lo_base,
   input  logic [ADDR_BITS-1:0]  lo_len,
   input  logic [ADDR_BITS-1:0]  hi_base,
   input  logic [ADDR_BITS-1:0]  hi_len,
   output logic [ADDR_BITS-1:0]  base,
   output logic [ADDR_BITS-1:0]  len
);
   import hlafp_pkg::*;

   logic [ADDR_BITS-1:0] base_ff, base_in, len_ff, len_in;
   logic [IDX_BITS-1:0]  me;

   assign me   = IDX_BITS'(MY_IDX);
   assign base = base_ff;
   assign len  = len_ff;

   // Pick next slot contents from command
   always_comb begin
      base_in = base_ff;
      len_in  = len_ff;
      unique case (ctl.cmd)
         CMD_LOAD: begin
            if (MY_IDX == 0) begin
               base_in = '0;
               len_in  = ctl.len[ADDR_BITS-1:0];
            end
         end
         CMD_SHRNK: begin
            if (target == me) begin
               base_in = base_ff + ctl.len[ADDR_BITS-1:0];
               len_in  = len_ff - ctl.len[ADDR_BITS-1:0];
            end
         end
         CMD_DEL: begin
            if (me >= target) begin
               base_in = hi_base;
               len_in  = hi_len;
            end
         end
         CMD_INS: begin
            if (me > target) begin
               base_in = lo_base;
               len_in  = lo_len;
            end else if (me == target) begin
               base_in = ctl.base[ADDR_BITS-1:0];
               len_in  = ctl.len[ADDR_BITS-1:0];
            end
         end
         CMD_SETL: begin
            if (target == me) len_in = ctl.len[ADDR_BITS-1:0];
         end
         CMD_SETBL: begin
            if (target == me) begin
               base_in = ctl.base[ADDR_BITS-1:0];
               len_in  = ctl.len[ADDR_BITS-1:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      len_ff  <= len_in;
   end

endmodule
